@@ hdl/sed_pkg.sv @@
// shared types, constants and helpers for the string escape decoder
package sed_pkg;

    localparam int LENGTH_BITS_DEF = 16;

    // scanner modes
    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_DIGITS = 2'd2
    } t_scan_mode;

    // sticky status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ESC   = 2'd1,
        ST_BAD_OCTAL = 2'd2,
        ST_BAD_HEX   = 2'd3
    } t_status;

    // characters the scanner looks for
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_LOWER_E   = 8'h65;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;

    // decoded values of the single-character escapes
    localparam logic [7:0] VAL_ESCAPE   = 8'h1B;
    localparam logic [7:0] VAL_CR       = 8'h0D;
    localparam logic [7:0] VAL_LF       = 8'h0A;

    // escape digit count after the first octal digit or after x
    localparam logic [1:0] DIGITS_START = 2'd2;

    function automatic logic is_octal(input logic [7:0] c);
        is_octal = (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = ((c >= CH_ZERO) && (c <= CH_NINE)) ||
                 ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) ||
                 ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
    endfunction

    // letters a-f and A-F share low bits 1..6, add nine to get 10..15
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + 4'd9;
        end
        hex_value = v;
    endfunction

endpackage

@@ hdl/sed_stream_if.sv @@
// valid/ready stream interfaces for source bytes and decoded words
interface sed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface sed_out_if #(
    parameter int LENGTH_BITS = sed_pkg::LENGTH_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [7:0]             out_byte;
    logic                   end_of_string;
    logic [1:0]             status;
    logic [LENGTH_BITS-1:0] string_length;

    modport source (output valid, output out_byte, output end_of_string,
                    output status, output string_length, input ready);
    modport sink   (input valid, input out_byte, input end_of_string,
                    input status, input string_length, output ready);
endinterface

@@ hdl/string_escape_decoder_unit.sv @@
// string escape decoder: removes backslash escapes from a byte stream
//
// usage
//   i_in  : one source byte per word; a zero byte ends the string
//   o_out : decoded words; a plain or decoded byte gives a word with
//           end_of_string low, status ok and string_length zero; the
//           terminating zero gives a word with end_of_string high, the
//           sticky status and the saturating length including the zero
//   a backslash, an x and every escape digit but the last give no word; after an
//   error the rest of the string gives no word until the terminator
//   path: an accepted byte waits in the input register, then passes the
//   scanner logic into the output register
//   throughput: one byte per cycle while the output is not stalled; the
//   scanner state is a small update that fits between the two registers
//   stall: when the output word is not taken, the input register and then
//   i_in.ready hold; ready goes low only while both registers are full and
//   the output is stalled
//   reset: synchronous active low, both registers empty, scanner in plain
//   text with no error and a zero count
module string_escape_decoder_unit #(
    parameter int LENGTH_BITS = sed_pkg::LENGTH_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sed_in_if.sink    i_in,
    sed_out_if.source o_out
);
    import sed_pkg::*;

    // input register
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;

    // scanner state
    t_scan_mode             r_mode,  n_mode;
    logic [7:0]             r_digit, n_digit;
    logic                   r_hex,   n_hex;
    logic [1:0]             r_left,  n_left;
    t_status                r_err,   n_err;
    logic [LENGTH_BITS-1:0] r_count, n_count;

    // output register
    logic                   r_out_valid;
    logic [7:0]             r_out_byte,  n_out_byte;
    logic                   r_out_eos,   n_out_eos;
    t_status                r_out_stat,  n_out_stat;
    logic [LENGTH_BITS-1:0] r_out_len,   n_out_len;

    logic                   emit;
    logic                   advance;
    logic [LENGTH_BITS-1:0] count_inc;
    logic [1:0]             left_dec;
    logic [7:0]             c;

    // the output register frees up whenever its word is taken
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;

    assign c         = r_in_byte;
    assign count_inc = (r_count != '1) ? r_count + 1'b1 : r_count;
    assign left_dec  = r_left - 2'd1;

    // scanner next state and result word
    always_comb begin
        n_mode     = r_mode;
        n_digit    = r_digit;
        n_hex      = r_hex;
        n_left     = r_left;
        n_err      = r_err;
        n_count    = r_count;
        emit       = 1'b0;
        n_out_byte = c;
        n_out_eos  = 1'b0;
        n_out_stat = ST_OK;
        n_out_len  = '0;

        if (c == CH_NUL) begin
            // terminator: report and start a fresh string
            emit       = 1'b1;
            n_out_byte = CH_NUL;
            n_out_eos  = 1'b1;
            n_out_stat = r_err;
            n_out_len  = count_inc;
            n_mode     = MODE_PLAIN;
            n_digit    = '0;
            n_hex      = 1'b0;
            n_left     = '0;
            n_err      = ST_OK;
            n_count    = '0;
        end else if (r_err == ST_OK) begin
            case (r_mode)
                MODE_ESC: begin
                    n_mode = MODE_PLAIN;
                    case (c)
                        CH_BACKSLASH: begin
                            emit       = 1'b1;
                            n_out_byte = CH_BACKSLASH;
                        end
                        CH_QUOTE: begin
                            emit       = 1'b1;
                            n_out_byte = CH_QUOTE;
                        end
                        CH_LOWER_E: begin
                            emit       = 1'b1;
                            n_out_byte = VAL_ESCAPE;
                        end
                        CH_LOWER_R: begin
                            emit       = 1'b1;
                            n_out_byte = VAL_CR;
                        end
                        CH_LOWER_N: begin
                            emit       = 1'b1;
                            n_out_byte = VAL_LF;
                        end
                        CH_LOWER_X: begin
                            n_digit = '0;
                            n_hex   = 1'b1;
                            n_left  = DIGITS_START;
                            n_mode  = MODE_DIGITS;
                        end
                        default: begin
                            if (is_octal(c)) begin
                                n_digit = {5'd0, c[2:0]};
                                n_hex   = 1'b0;
                                n_left  = DIGITS_START;
                                n_mode  = MODE_DIGITS;
                            end else begin
                                n_err = ST_BAD_ESC;
                            end
                        end
                    endcase
                    if (emit) begin
                        n_count = count_inc;
                    end
                end
                MODE_DIGITS: begin
                    if (r_hex && !is_hex(c)) begin
                        n_err  = ST_BAD_HEX;
                        n_mode = MODE_PLAIN;
                    end else if (!r_hex && !is_octal(c)) begin
                        n_err  = ST_BAD_OCTAL;
                        n_mode = MODE_PLAIN;
                    end else begin
                        if (r_hex) begin
                            n_digit = {r_digit[3:0], hex_value(c)};
                        end else begin
                            n_digit = {r_digit[4:0], c[2:0]};
                        end
                        n_left = left_dec;
                        if (left_dec == 2'd0) begin
                            n_mode     = MODE_PLAIN;
                            emit       = 1'b1;
                            n_out_byte = n_digit;
                            n_count    = count_inc;
                        end
                    end
                end
                default: begin
                    // plain text, also the unused mode code
                    if (c == CH_BACKSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        emit    = 1'b1;
                        n_count = count_inc;
                    end
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    // scanner state, updated as the held byte moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PLAIN;
            r_digit <= '0;
            r_hex   <= 1'b0;
            r_left  <= '0;
            r_err   <= ST_OK;
            r_count <= '0;
        end else if (r_in_valid && advance) begin
            r_mode  <= n_mode;
            r_digit <= n_digit;
            r_hex   <= n_hex;
            r_left  <= n_left;
            r_err   <= n_err;
            r_count <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && emit;
        end
        if (advance && r_in_valid && emit) begin
            r_out_byte <= n_out_byte;
            r_out_eos  <= n_out_eos;
            r_out_stat <= n_out_stat;
            r_out_len  <= n_out_len;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.end_of_string = r_out_eos;
    assign o_out.status        = r_out_stat;
    assign o_out.string_length = r_out_len;

`ifndef ASSERT_OFF
    // data words never carry a status or a length
    a_data_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_eos |-> r_out_stat == ST_OK && r_out_len == '0)
        else $error("data word with status or length");

    // once an error is pending the scanner sits in plain text
    a_err_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ST_OK |-> r_mode == MODE_PLAIN)
        else $error("error pending outside plain mode");

    // inside an escape number there is always a digit still to come
    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_DIGITS |-> r_left != 2'd0)
        else $error("digit mode with no digits left");

    // a held byte is kept while the output stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte))
        else $error("held byte lost during stall");

    // a terminator leaves a clean scanner for the next string
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && advance && r_in_byte == CH_NUL
        |=> r_count == '0 && r_err == ST_OK && r_mode == MODE_PLAIN)
        else $error("state not cleared after terminator");
`endif

endmodule
